// File: rtl/bba_pkg.sv
// shared types, codes and helper functions of the buddy block allocator
`default_nettype none
package bba_pkg;

   localparam int MaxOrder = 10;
   localparam int IdxBits = MaxOrder + 1;
   localparam int TreeSlots = 1 << IdxBits;

   typedef logic [IdxBits-1:0] idx_type;
   typedef logic [IdxBits:0] scan_type;
   typedef logic [MaxOrder-1:0] addr_type;
   typedef logic [3:0] order_type;
   typedef logic [10:0] size_type;
   typedef logic [10:0] count_type;
   typedef logic [15:0] denied_type;

   typedef enum logic [1:0] {
      NODE_ABSENT = 2'd0,
      NODE_FREE = 2'd1,
      NODE_USED = 2'd2,
      NODE_SPLIT = 2'd3
   } node_type;

   typedef enum logic [1:0] {
      STAT_OK = 2'd0,
      STAT_DENIED = 2'd1,
      STAT_BAD_FREE = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN_EQ,
      ST_SCAN_UP,
      ST_SPLIT,
      ST_SPLIT_R,
      ST_WALK_RD,
      ST_WALK_CK,
      ST_MERGE_RD,
      ST_MERGE_CK,
      ST_MERGE_B,
      ST_MERGE_C,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0] status;
      addr_type block_address;
      order_type block_order;
      count_type live_allocations;
      denied_type denied_count;
   } res_type;

   typedef struct packed {
      logic valid;
      order_type data;
   } cfg_wr_type;

   typedef struct packed {
      logic wr_en;
      idx_type wr_addr;
      logic [1:0] wr_data;
      idx_type rd_addr;
   } ram_ctl_type;

   function automatic order_type depth_of(idx_type idx);
      order_type r;
      r = '0;
      for (int b = 0; b < IdxBits; b++) begin
         if (idx[b]) begin
            r = order_type'(b);
         end
      end
      return r;
   endfunction

   function automatic addr_type node_addr(idx_type idx, order_type dep, order_type po);
      idx_type off;
      idx_type sh;
      off = idx - (idx_type'(1) << dep);
      sh = off << (po - dep);
      return addr_type'(sh);
   endfunction

   function automatic order_type ceil_log2(size_type size);
      size_type m;
      order_type r;
      m = size - size_type'(1);
      r = '0;
      for (int b = 0; b < 11; b++) begin
         if (m[b]) begin
            r = order_type'(b + 1);
         end
      end
      return r;
   endfunction

   function automatic order_type clamp_order(order_type v);
      order_type r;
      r = v;
      if (v < order_type'(1)) begin
         r = order_type'(1);
      end
      if (v > order_type'(MaxOrder)) begin
         r = order_type'(MaxOrder);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// File: rtl/bba_if.sv
// handshake channel interfaces of the buddy block allocator
`default_nettype none
interface bba_req_if;
   logic valid;
   logic ready;
   logic mode;
   logic [10:0] request_size;
   logic [9:0] free_address;
   modport source (output valid, output mode, output request_size, output free_address,
                   input ready);
   modport sink (input valid, input mode, input request_size, input free_address,
                 output ready);
endinterface

interface bba_rsp_if;
   logic valid;
   logic ready;
   logic [1:0] status;
   logic [9:0] block_address;
   logic [3:0] block_order;
   logic [10:0] live_allocations;
   logic [15:0] denied_count;
   modport source (output valid, output status, output block_address, output block_order,
                   output live_allocations, output denied_count, input ready);
   modport sink (input valid, input status, input block_address, input block_order,
                 input live_allocations, input denied_count, output ready);
endinterface

interface bba_csr_if;
   logic valid;
   logic ready;
   logic [3:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/buddy_block_allocator_unit.sv
// buddy allocator top level: tree ram, sequencer and output register
// allocate: scan the exact level first, then the larger levels for the free block
//    with the lowest address, then split that block down to the wanted level
// free: walk the tree levels down to the block, then merge it with free buddies upward
// one item at a time; the single ram read port sets the scan rate of one node a cycle
// reset and every pool_order write clear all 2048 tree ram slots, no item taken
`default_nettype none
module buddy_block_allocator_unit import bba_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   bba_req_if.sink req,
   bba_rsp_if.source rsp,
   bba_csr_if.sink csr
);
   cfg_wr_type cfg;
   ram_ctl_type ram;
   logic [1:0] ram_rd_data;
   res_type res;
   logic res_valid;
   logic res_take;
   logic rsp_valid_ff, rsp_valid_in;
   res_type rsp_data_ff, rsp_data_in;

   assign csr.ready = 1'b1;
   assign cfg.valid = csr.valid;
   assign cfg.data = csr.data;

   bba_ram #(
      .Width(2),
      .Depth(TreeSlots)
   ) u_tree (
      .clock(clock),
      .wr_en(ram.wr_en),
      .wr_addr(ram.wr_addr),
      .wr_data(ram.wr_data),
      .rd_addr(ram.rd_addr),
      .rd_data(ram_rd_data)
   );

   bba_engine u_engine (
      .clock(clock),
      .reset(reset),
      .cfg(cfg),
      .req_valid(req.valid),
      .req_ready(req.ready),
      .req_mode(req.mode),
      .req_size(req.request_size),
      .req_addr(req.free_address),
      .res_valid(res_valid),
      .res_take(res_take),
      .res(res),
      .ram(ram),
      .ram_rd_data(ram_rd_data)
   );

   assign res_take = !rsp_valid_ff || rsp.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_valid && res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.status = rsp_data_ff.status;
   assign rsp.block_address = rsp_data_ff.block_address;
   assign rsp.block_order = rsp_data_ff.block_order;
   assign rsp.live_allocations = rsp_data_ff.live_allocations;
   assign rsp.denied_count = rsp_data_ff.denied_count;
endmodule
`default_nettype wire

// File: rtl/bba_ram.sv
// generic single write port ram with registered read
`default_nettype none
module bba_ram #(
   parameter int Width = 2,
   parameter int Depth = 2048
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [$clog2(Depth)-1:0] wr_addr,
   input wire logic [Width-1:0] wr_data,
   input wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: rtl/bba_engine.sv
// sequencer that searches, splits and merges the buddy tree held in ram
`default_nettype none
module bba_engine import bba_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire cfg_wr_type cfg,
   input wire logic req_valid,
   output logic req_ready,
   input wire logic req_mode,
   input wire size_type req_size,
   input wire addr_type req_addr,
   output logic res_valid,
   input wire logic res_take,
   output res_type res,
   output ram_ctl_type ram,
   input wire logic [1:0] ram_rd_data
);
   state_type state_ff, state_in;
   order_type po_ff, po_in;
   scan_type clr_ff, clr_in;
   idx_type cur_ff, cur_in;
   order_type dep_ff, dep_in;
   order_type want_ff, want_in;
   order_type k_ff, k_in;
   scan_type scan_ff, scan_in;
   scan_type end_ff, end_in;
   logic chk_vld_ff, chk_vld_in;
   idx_type chk_idx_ff, chk_idx_in;
   logic best_vld_ff, best_vld_in;
   addr_type best_addr_ff, best_addr_in;
   idx_type best_idx_ff, best_idx_in;
   order_type best_dep_ff, best_dep_in;
   addr_type faddr_ff, faddr_in;
   count_type live_ff, live_in;
   denied_type den_ff, den_in;
   status_type rstat_ff, rstat_in;
   addr_type raddr_ff, raddr_in;
   order_type rord_ff, rord_in;

   node_type rd_node;
   logic deny;
   addr_type cand_addr;
   addr_type sh_addr;

   assign rd_node = node_type'(ram_rd_data);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         po_ff <= order_type'(MaxOrder);
         clr_ff <= '0;
         live_ff <= '0;
         den_ff <= '0;
         chk_vld_ff <= 1'b0;
         best_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         po_ff <= po_in;
         clr_ff <= clr_in;
         live_ff <= live_in;
         den_ff <= den_in;
         chk_vld_ff <= chk_vld_in;
         best_vld_ff <= best_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      dep_ff <= dep_in;
      want_ff <= want_in;
      k_ff <= k_in;
      scan_ff <= scan_in;
      end_ff <= end_in;
      chk_idx_ff <= chk_idx_in;
      best_addr_ff <= best_addr_in;
      best_idx_ff <= best_idx_in;
      best_dep_ff <= best_dep_in;
      faddr_ff <= faddr_in;
      rstat_ff <= rstat_in;
      raddr_ff <= raddr_in;
      rord_ff <= rord_in;
   end

   always_comb begin
      state_in = state_ff;
      po_in = po_ff;
      clr_in = clr_ff;
      cur_in = cur_ff;
      dep_in = dep_ff;
      want_in = want_ff;
      k_in = k_ff;
      scan_in = scan_ff;
      end_in = end_ff;
      chk_vld_in = chk_vld_ff;
      chk_idx_in = chk_idx_ff;
      best_vld_in = best_vld_ff;
      best_addr_in = best_addr_ff;
      best_idx_in = best_idx_ff;
      best_dep_in = best_dep_ff;
      faddr_in = faddr_ff;
      live_in = live_ff;
      den_in = den_ff;
      rstat_in = rstat_ff;
      raddr_in = raddr_ff;
      rord_in = rord_ff;
      req_ready = 1'b0;
      res_valid = 1'b0;
      deny = 1'b0;
      ram = '0;
      cand_addr = node_addr(chk_idx_ff, depth_of(chk_idx_ff), po_ff);
      sh_addr = faddr_ff >> (po_ff - dep_ff - order_type'(1));

      unique case (state_ff)
         ST_CLEAR: begin
            ram.wr_en = 1'b1;
            ram.wr_addr = clr_ff[IdxBits-1:0];
            ram.wr_data = (clr_ff == scan_type'(1)) ? NODE_FREE : NODE_ABSENT;
            clr_in = clr_ff + scan_type'(1);
            if (clr_ff == scan_type'(TreeSlots - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (!req_mode) begin
                  if (req_size == '0 || req_size > (size_type'(1) << po_ff)) begin
                     deny = 1'b1;
                  end else begin
                     k_in = ceil_log2(req_size);
                     want_in = po_ff - ceil_log2(req_size);
                     scan_in = scan_type'(1) << (po_ff - ceil_log2(req_size));
                     end_in = (scan_type'(2) << (po_ff - ceil_log2(req_size)))
                              - scan_type'(1);
                     chk_vld_in = 1'b0;
                     state_in = ST_SCAN_EQ;
                  end
               end else begin
                  faddr_in = req_addr;
                  if ({1'b0, req_addr} >= (size_type'(1) << po_ff)) begin
                     rstat_in = STAT_BAD_FREE;
                     raddr_in = '0;
                     rord_in = '0;
                     state_in = ST_DONE;
                  end else begin
                     cur_in = idx_type'(1);
                     dep_in = '0;
                     state_in = ST_WALK_RD;
                  end
               end
            end
         end
         ST_SCAN_EQ: begin
            ram.rd_addr = scan_ff[IdxBits-1:0];
            chk_vld_in = (scan_ff <= end_ff);
            chk_idx_in = scan_ff[IdxBits-1:0];
            if (scan_ff <= end_ff) begin
               scan_in = scan_ff + scan_type'(1);
            end
            if (chk_vld_ff && rd_node == NODE_FREE) begin
               cur_in = chk_idx_ff;
               dep_in = want_ff;
               chk_vld_in = 1'b0;
               state_in = ST_SPLIT;
            end else if (!chk_vld_ff && scan_ff > end_ff) begin
               if (want_ff == '0) begin
                  deny = 1'b1;
               end else begin
                  scan_in = scan_type'(1);
                  end_in = (scan_type'(1) << want_ff) - scan_type'(1);
                  best_vld_in = 1'b0;
                  chk_vld_in = 1'b0;
                  state_in = ST_SCAN_UP;
               end
            end
         end
         ST_SCAN_UP: begin
            ram.rd_addr = scan_ff[IdxBits-1:0];
            chk_vld_in = (scan_ff <= end_ff);
            chk_idx_in = scan_ff[IdxBits-1:0];
            if (scan_ff <= end_ff) begin
               scan_in = scan_ff + scan_type'(1);
            end
            if (chk_vld_ff && rd_node == NODE_FREE) begin
               if (!best_vld_ff || cand_addr < best_addr_ff) begin
                  best_vld_in = 1'b1;
                  best_addr_in = cand_addr;
                  best_idx_in = chk_idx_ff;
                  best_dep_in = depth_of(chk_idx_ff);
               end
            end else if (!chk_vld_ff && scan_ff > end_ff) begin
               chk_vld_in = 1'b0;
               if (best_vld_ff) begin
                  cur_in = best_idx_ff;
                  dep_in = best_dep_ff;
                  state_in = ST_SPLIT;
               end else begin
                  deny = 1'b1;
               end
            end
         end
         ST_SPLIT: begin
            ram.wr_en = 1'b1;
            ram.wr_addr = cur_ff;
            if (dep_ff < want_ff) begin
               ram.wr_data = NODE_SPLIT;
               state_in = ST_SPLIT_R;
            end else begin
               ram.wr_data = NODE_USED;
               live_in = live_ff + count_type'(1);
               rstat_in = STAT_OK;
               raddr_in = node_addr(cur_ff, dep_ff, po_ff);
               rord_in = k_ff;
               state_in = ST_DONE;
            end
         end
         ST_SPLIT_R: begin
            ram.wr_en = 1'b1;
            ram.wr_addr = {cur_ff[IdxBits-2:0], 1'b1};
            ram.wr_data = NODE_FREE;
            cur_in = {cur_ff[IdxBits-2:0], 1'b0};
            dep_in = dep_ff + order_type'(1);
            state_in = ST_SPLIT;
         end
         ST_WALK_RD: begin
            ram.rd_addr = cur_ff;
            state_in = ST_WALK_CK;
         end
         ST_WALK_CK: begin
            if (rd_node == NODE_SPLIT && dep_ff < po_ff) begin
               cur_in = {cur_ff[IdxBits-2:0], sh_addr[0]};
               dep_in = dep_ff + order_type'(1);
               state_in = ST_WALK_RD;
            end else if (rd_node != NODE_USED || node_addr(cur_ff, dep_ff, po_ff) != faddr_ff)
            begin
               rstat_in = STAT_BAD_FREE;
               raddr_in = '0;
               rord_in = '0;
               state_in = ST_DONE;
            end else begin
               ram.wr_en = 1'b1;
               ram.wr_addr = cur_ff;
               ram.wr_data = NODE_FREE;
               if (live_ff != '0) begin
                  live_in = live_ff - count_type'(1);
               end
               rstat_in = STAT_OK;
               raddr_in = faddr_ff;
               rord_in = po_ff - dep_ff;
               state_in = ST_MERGE_RD;
            end
         end
         ST_MERGE_RD: begin
            ram.rd_addr = cur_ff ^ idx_type'(1);
            state_in = (cur_ff > idx_type'(1)) ? ST_MERGE_CK : ST_DONE;
         end
         ST_MERGE_CK: begin
            if (rd_node == NODE_FREE) begin
               ram.wr_en = 1'b1;
               ram.wr_addr = cur_ff;
               ram.wr_data = NODE_ABSENT;
               state_in = ST_MERGE_B;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_MERGE_B: begin
            ram.wr_en = 1'b1;
            ram.wr_addr = cur_ff ^ idx_type'(1);
            ram.wr_data = NODE_ABSENT;
            state_in = ST_MERGE_C;
         end
         ST_MERGE_C: begin
            ram.wr_en = 1'b1;
            ram.wr_addr = cur_ff >> 1;
            ram.wr_data = NODE_FREE;
            cur_in = cur_ff >> 1;
            state_in = ST_MERGE_RD;
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in = '0;
         end
      endcase

      if (deny) begin
         if (den_ff != 16'hFFFF) begin
            den_in = den_ff + denied_type'(1);
         end
         rstat_in = STAT_DENIED;
         raddr_in = '0;
         rord_in = '0;
         state_in = ST_DONE;
      end

      if (cfg.valid) begin
         po_in = clamp_order(cfg.data);
         live_in = '0;
         clr_in = '0;
         state_in = ST_CLEAR;
      end
   end

   assign res.status = rstat_ff;
   assign res.block_address = raddr_ff;
   assign res.block_order = rord_ff;
   assign res.live_allocations = live_ff;
   assign res.denied_count = den_ff;

   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      live_ff <= count_type'(1024))
      else $error("live allocation count beyond pool");
   a_denied_mono: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> den_ff >= $past(den_ff))
      else $error("denied count went down");
   a_cfg_clear: assert property (@(posedge clock) disable iff (reset)
      cfg.valid |=> state_ff == ST_CLEAR && clr_ff == '0 && live_ff == '0)
      else $error("pool not rebuilt after config write");
   a_no_slot0: assert property (@(posedge clock) disable iff (reset)
      (ram.wr_en && state_ff != ST_CLEAR) |-> ram.wr_addr != '0)
      else $error("tree write to unused slot");
   a_order_bound: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> rord_ff <= po_ff)
      else $error("block order beyond pool order");
endmodule
`default_nettype wire

// File: tb/buddy_block_allocator_unit_test.sv
// self-checking testbench of the buddy block allocator: directed and random items, scoreboard
`default_nettype none
module buddy_block_allocator_unit_test;
   import bba_pkg::*;

   typedef struct {
      logic [1:0] status;
      addr_type addr;
      order_type order;
      count_type live;
      denied_type denied;
   } alloc_result_type;

   int mismatches;

   task automatic report_mismatch(string msg);
      mismatches++;
      $display("mismatch: %s", msg);
   endtask

   class alloc_scoreboard;
      node_type tree[TreeSlots];
      int unsigned pool_ord;
      int unsigned live_blocks;
      int unsigned denied_total;
      alloc_result_type pending[$];
      logic [9:0] held_addrs[$];

      function void rebuild_pool(int unsigned po);
         foreach (tree[i]) tree[i] = NODE_ABSENT;
         tree[1] = NODE_FREE;
         pool_ord = po;
         live_blocks = 0;
         held_addrs.delete();
      endfunction

      function int unsigned base_of(int unsigned idx, int unsigned dep);
         return (idx - (1 << dep)) << (pool_ord - dep);
      endfunction

      function void push_result(logic [1:0] st, int unsigned a, int unsigned o);
         alloc_result_type r;
         r.status = st;
         r.addr = addr_type'(a);
         r.order = order_type'(o);
         r.live = count_type'(live_blocks);
         r.denied = denied_type'(denied_total);
         pending.push_back(r);
      endfunction

      function void refuse();
         if (denied_total < 16'hffff) denied_total++;
         push_result(STAT_DENIED, 0, 0);
      endfunction

      function void grant(int unsigned size);
         int unsigned k, want, found, fdep, best;
         bit have;
         k = 0;
         found = 0;
         fdep = 0;
         best = 0;
         have = 0;
         if (size == 0 || size > (1 << pool_ord)) begin
            refuse();
            return;
         end
         while ((1 << k) < size) k++;
         want = pool_ord - k;
         for (int unsigned i = 1 << want; i < (2 << want); i++) begin
            if (tree[i] == NODE_FREE) begin
               found = i;
               fdep = want;
               have = 1;
               break;
            end
         end
         if (!have) begin
            for (int unsigned d = 0; d < want; d++) begin
               for (int unsigned i = 1 << d; i < (2 << d); i++) begin
                  if (tree[i] == NODE_FREE) begin
                     if (!have || base_of(i, d) < best) begin
                        have = 1;
                        best = base_of(i, d);
                        found = i;
                        fdep = d;
                     end
                     break;
                  end
               end
            end
            if (!have) begin
               refuse();
               return;
            end
            while (fdep < want) begin
               tree[found] = NODE_SPLIT;
               tree[2*found] = NODE_FREE;
               tree[2*found+1] = NODE_FREE;
               found = 2 * found;
               fdep++;
            end
         end
         tree[found] = NODE_USED;
         live_blocks++;
         held_addrs.push_back(10'(base_of(found, fdep)));
         push_result(STAT_OK, base_of(found, fdep), k);
      endfunction

      function void release_block(int unsigned a);
         int unsigned idx, dep, half;
         idx = 1;
         dep = 0;
         if (a >= (1 << pool_ord)) begin
            push_result(STAT_BAD_FREE, 0, 0);
            return;
         end
         while (tree[idx] == NODE_SPLIT && dep < pool_ord) begin
            half = 1 << (pool_ord - dep - 1);
            idx = 2 * idx + (((a - base_of(idx, dep)) >= half) ? 1 : 0);
            dep++;
         end
         if (tree[idx] != NODE_USED || base_of(idx, dep) != a) begin
            push_result(STAT_BAD_FREE, 0, 0);
            return;
         end
         tree[idx] = NODE_FREE;
         if (live_blocks > 0) live_blocks--;
         foreach (held_addrs[i]) if (held_addrs[i] == a) begin
            held_addrs.delete(i);
            break;
         end
         push_result(STAT_OK, a, pool_ord - dep);
         while (idx > 1 && tree[idx ^ 1] == NODE_FREE) begin
            tree[idx] = NODE_ABSENT;
            tree[idx ^ 1] = NODE_ABSENT;
            idx >>= 1;
            tree[idx] = NODE_FREE;
         end
      endfunction

      function void note_request(logic m, logic [10:0] sz, logic [9:0] fa);
         if (m == 1'b0) grant(sz);
         else release_block(fa);
      endfunction

      task check_result(logic [1:0] st, logic [9:0] a, logic [3:0] o, logic [10:0] lv,
                        logic [15:0] dn);
         alloc_result_type e;
         if (pending.size() == 0) begin
            report_mismatch("result with no request outstanding");
            return;
         end
         e = pending.pop_front();
         if (st !== e.status) report_mismatch($sformatf("status %0d exp %0d", st, e.status));
         if (a !== e.addr) report_mismatch($sformatf("address %0d exp %0d", a, e.addr));
         if (o !== e.order) report_mismatch($sformatf("order %0d exp %0d", o, e.order));
         if (lv !== e.live) report_mismatch($sformatf("live %0d exp %0d", lv, e.live));
         if (dn !== e.denied) report_mismatch($sformatf("denied %0d exp %0d", dn, e.denied));
      endtask
   endclass

   logic clock;
   logic reset;
   bit stim_done;
   alloc_scoreboard sb;

   bba_req_if req ();
   bba_rsp_if rsp ();
   bba_csr_if csr ();

   buddy_block_allocator_unit dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source),
      .csr(csr.sink)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      req.valid = 1'b0;
      req.mode = 1'b0;
      req.request_size = '0;
      req.free_address = '0;
      csr.valid = 1'b0;
      csr.data = '0;
      rsp.ready = 1'b0;
   end

   task automatic send_item(logic m, logic [10:0] sz, logic [9:0] fa);
      int unsigned idle;
      idle = $urandom_range(0, 8);
      @(negedge clock);
      if (idle > 0) begin
         req.valid <= 1'b0;
         repeat (idle) @(negedge clock);
      end
      req.valid <= 1'b1;
      req.mode <= m;
      req.request_size <= sz;
      req.free_address <= fa;
      do @(posedge clock); while (!req.ready);
      sb.note_request(m, sz, fa);
   endtask

   task automatic stop_items();
      @(negedge clock);
      req.valid <= 1'b0;
   endtask

   task automatic write_pool_order(logic [3:0] v);
      int unsigned c;
      stop_items();
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      csr.valid <= 1'b1;
      csr.data <= v;
      do @(posedge clock); while (!csr.ready);
      c = v;
      if (c < 1) c = 1;
      if (c > MaxOrder) c = MaxOrder;
      sb.rebuild_pool(c);
      @(negedge clock);
      csr.valid <= 1'b0;
   endtask

   task automatic random_items(int n);
      int unsigned r, sz;
      logic [9:0] fa;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 45) begin
            sz = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                 : $urandom_range(1, 1 << ($urandom_range(0, sb.pool_ord)));
            send_item(1'b0, sz[10:0], 10'($urandom));
         end else if (r < 85 && sb.held_addrs.size() > 0) begin
            fa = sb.held_addrs[$urandom_range(0, sb.held_addrs.size() - 1)];
            send_item(1'b1, 11'($urandom), fa);
         end else begin
            send_item(1'b1, 11'($urandom), 10'($urandom));
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         sb.check_result(rsp.status, rsp.block_address, rsp.block_order,
                         rsp.live_allocations, rsp.denied_count);
   end

   initial begin
      int stall;
      stall = 0;
      @(negedge clock);
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            stall--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
            if (rsp.valid && $urandom_range(0, 3) != 0) stall = $urandom_range(0, 8);
         end
      end
   end

   initial begin
      sb = new();
      sb.rebuild_pool(MaxOrder);
      sb.denied_total = 0;
      mismatches = 0;
      stim_done = 0;
      reset = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_item(1'b0, 11'd0, 10'd0);
      send_item(1'b0, 11'd1025, 10'd0);
      send_item(1'b0, 11'd2047, 10'h3ff);
      send_item(1'b0, 11'd1024, 10'd0);
      send_item(1'b0, 11'd1, 10'd0);
      send_item(1'b1, 11'd0, 10'd0);
      send_item(1'b1, 11'd0, 10'd0);
      send_item(1'b0, 11'd1, 10'd0);
      send_item(1'b0, 11'd3, 10'd0);
      send_item(1'b0, 11'd512, 10'd0);
      send_item(1'b0, 11'd512, 10'd0);
      send_item(1'b1, 11'd0, 10'd4);
      send_item(1'b1, 11'd0, 10'd5);
      send_item(1'b1, 11'd0, 10'h3ff);
      send_item(1'b1, 11'h7ff, 10'd512);
      send_item(1'b1, 11'd0, 10'd0);
      send_item(1'b0, 11'd1024, 10'd0);
      write_pool_order(4'd1);
      send_item(1'b0, 11'd1, 10'd0);
      send_item(1'b0, 11'd1, 10'd0);
      send_item(1'b0, 11'd1, 10'd0);
      send_item(1'b1, 11'd0, 10'd2);
      send_item(1'b1, 11'd0, 10'd1);
      send_item(1'b0, 11'd3, 10'd0);
      random_items(120);
      write_pool_order(4'd0);
      random_items(120);
      write_pool_order(4'd15);
      random_items(120);
      write_pool_order(4'd4);
      random_items(300);
      write_pool_order(4'd6);
      random_items(220);
      write_pool_order(4'd10);
      random_items(200);
      stop_items();
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (mismatches == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

   initial begin
      #20000000;
      $display("Verification failed");
      $finish;
   end
endmodule
`default_nettype wire
